>>> hdl/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types and constants for the mesh tangent accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mta_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned PROD_W   = 66;
  localparam int unsigned WIDE_W   = 67;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned QBITS    = 33;
  localparam int unsigned MUL_STEPS = 14;
  localparam int unsigned N_QUOT   = 6;
  localparam int unsigned N_RES    = 7;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [9:0]         first_index;
    logic [9:0]         second_index;
    logic [9:0]         third_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FETCH, S_DIFF, S_MUL, S_CHK, S_DIV, S_DIVW,
    S_ARD, S_AWR, S_RRD, S_ROUT
  } state_e;

  typedef enum logic [1:0] {
    D_IDLE, D_CHECK, D_ITER, D_DONE
  } div_state_e;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       vtx_rd;
    logic       vtx_cap;
    logic [1:0] corner;
    logic [1:0] cap_corner;
    logic       diff_en;
    logic       mul_en;
    logic [3:0] mul_step;
    logic       div_start;
    logic [2:0] div_sel;
    logic       sum_rd;
    logic       sum_wr;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic det_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/mta_in_if.sv
// ----------------------------------------------------------------------------
// mta_in_if
// Input item channel: valid, ready and the input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mta_in_if import mta_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/mta_out_if.sv
// ----------------------------------------------------------------------------
// mta_out_if
// Result item channel: valid, ready and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mta_out_if import mta_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/mta_div.sv
// ----------------------------------------------------------------------------
// mta_div
// Restoring divider: (num * 2^16) / den, truncated, clamped to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_div import mta_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [WIDE_W-1:0] num_i,
  input  wire logic signed [WIDE_W-1:0] den_i,
  output logic                          done_o,
  output logic signed [Q_W-1:0]         quo_o,
  output logic                          clamp_o
);

  localparam int unsigned NW = WIDE_W + FRAC_W;

  div_state_e         st_q, st_d;
  logic [WIDE_W-1:0]  rem_q, d_q;
  logic [QBITS-1:0]   low_q, q_q;
  logic [5:0]         cnt_q;
  logic               neg_q, over_q;

  logic [WIDE_W-1:0]  num_mag, den_mag;
  logic [NW-1:0]      n_wide;
  logic [WIDE_W:0]    trial;
  logic               fits;
  logic [QBITS-1:0]   limit;
  logic               clamp;
  logic [Q_W-1:0]     val;

  assign num_mag = num_i[WIDE_W-1] ? WIDE_W'(-num_i) : WIDE_W'(num_i);
  assign den_mag = den_i[WIDE_W-1] ? WIDE_W'(-den_i) : WIDE_W'(den_i);
  assign n_wide  = {num_mag, FRAC_W'(0)};
  assign trial   = {rem_q, low_q[QBITS-1]};
  assign fits    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= D_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      D_IDLE:  if (start_i) st_d = D_CHECK;
      D_CHECK: st_d = (rem_q >= d_q) ? D_DONE : D_ITER;
      D_ITER:  if (cnt_q == 6'(QBITS - 1)) st_d = D_DONE;
      D_DONE:  st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == D_IDLE && start_i) begin
      neg_q  <= num_i[WIDE_W-1] ^ den_i[WIDE_W-1];
      d_q    <= den_mag;
      rem_q  <= WIDE_W'(n_wide[NW-1:QBITS]);
      low_q  <= n_wide[QBITS-1:0];
      q_q    <= '0;
      cnt_q  <= '0;
      over_q <= 1'b0;
    end else if (st_q == D_CHECK) begin
      over_q <= rem_q >= d_q;
    end else if (st_q == D_ITER) begin
      rem_q <= fits ? WIDE_W'(trial - {1'b0, d_q}) : WIDE_W'(trial);
      q_q   <= {q_q[QBITS-2:0], fits};
      low_q <= {low_q[QBITS-2:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
    end
  end

  assign limit   = neg_q ? QBITS'(33'h0_8000_0000) : QBITS'(33'h0_7FFF_FFFF);
  assign clamp   = over_q || (q_q > limit);
  assign val     = clamp ? limit[Q_W-1:0] : q_q[Q_W-1:0];
  assign quo_o   = neg_q ? -val : val;
  assign clamp_o = clamp;
  assign done_o  = (st_q == D_DONE);

endmodule

`default_nettype wire

>>> hdl/mta_datapath.sv
// ----------------------------------------------------------------------------
// mta_datapath
// Vertex and sum memories, edge differences, shared multiplier, divider,
// saturating accumulation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_datapath import mta_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_t      cmd_i,
  output sts_t           sts_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned AW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;

  typedef struct packed {
    logic signed [31:0] tx, ty, tz, bx, by, bz;
    logic               mark;
  } sum_t;

  in_item_t item_q;
  vtx_t     vmem [MAX_VERTICES];
  sum_t     smem [MAX_VERTICES];
  vtx_t     vrd_q;
  sum_t     srd_q;
  vtx_t     vtx_q [3];

  logic signed [DIFF_W-1:0] e1_q [3];
  logic signed [DIFF_W-1:0] e2_q [3];
  logic signed [DIFF_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DIFF_W-1:0] ma, mb;
  logic signed [PROD_W-1:0] prod_q, hold_q;
  logic [3:0]               pstep_q;
  logic                     pval_q;
  logic signed [WIDE_W-1:0] res_q [N_RES];
  logic signed [Q_W-1:0]    quo_q [N_QUOT];
  logic                     clamp_q;
  logic [2:0]               dsel_q;

  logic                     div_done, div_clamp;
  logic signed [Q_W-1:0]    div_quo;
  logic [IDX_W-1:0]         idx;
  logic [AW-1:0]            addr, addr_first;
  logic                     ok0, ok1, ok2, in_range;
  sum_t                     new_sum;
  logic [5:0]               sats;
  logic [32:0]              r0, r1, r2, r3, r4, r5;

  logic                     out_valid_q;
  out_item_t                out_q;

  function automatic logic [32:0] sat_add(input logic signed [31:0] s,
                                          input logic signed [31:0] a);
    logic signed [32:0] t;
    t = 33'(s) + 33'(a);
    if (t[32] != t[31]) begin
      return t[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end
    return {1'b0, t[31:0]};
  endfunction

  always_comb begin
    unique case (cmd_i.corner)
      2'd1:    idx = item_q.second_index;
      2'd2:    idx = item_q.third_index;
      default: idx = item_q.first_index;
    endcase
  end

  assign addr       = AW'(idx);
  assign addr_first = AW'(item_q.first_index);
  assign ok0        = 32'(item_q.first_index)  < MAX_VERTICES;
  assign ok1        = 32'(item_q.second_index) < MAX_VERTICES;
  assign ok2        = 32'(item_q.third_index)  < MAX_VERTICES;
  assign in_range   = (item_q.mode == MODE_TRI) ? (ok0 && ok1 && ok2) : ok0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // vertex store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && in_range) begin
      vmem[addr_first] <= '{item_q.pos_x, item_q.pos_y, item_q.pos_z,
                            item_q.tex_u, item_q.tex_v};
    end
    if (cmd_i.vtx_rd) vrd_q <= vmem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_cap) vtx_q[cmd_i.cap_corner] <= vrd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      e1_q[0] <= DIFF_W'(vtx_q[1].pos_x) - DIFF_W'(vtx_q[0].pos_x);
      e1_q[1] <= DIFF_W'(vtx_q[1].pos_y) - DIFF_W'(vtx_q[0].pos_y);
      e1_q[2] <= DIFF_W'(vtx_q[1].pos_z) - DIFF_W'(vtx_q[0].pos_z);
      e2_q[0] <= DIFF_W'(vtx_q[2].pos_x) - DIFF_W'(vtx_q[0].pos_x);
      e2_q[1] <= DIFF_W'(vtx_q[2].pos_y) - DIFF_W'(vtx_q[0].pos_y);
      e2_q[2] <= DIFF_W'(vtx_q[2].pos_z) - DIFF_W'(vtx_q[0].pos_z);
      du1_q   <= DIFF_W'(vtx_q[1].tex_u) - DIFF_W'(vtx_q[0].tex_u);
      dv1_q   <= DIFF_W'(vtx_q[1].tex_v) - DIFF_W'(vtx_q[0].tex_v);
      du2_q   <= DIFF_W'(vtx_q[2].tex_u) - DIFF_W'(vtx_q[0].tex_u);
      dv2_q   <= DIFF_W'(vtx_q[2].tex_v) - DIFF_W'(vtx_q[0].tex_v);
    end
  end

  // product pairs: det, then tangent/bitangent numerators per axis
  always_comb begin
    unique case (cmd_i.mul_step)
      4'd0:    begin ma = du1_q;   mb = dv2_q; end
      4'd1:    begin ma = dv1_q;   mb = du2_q; end
      4'd2:    begin ma = e1_q[0]; mb = dv2_q; end
      4'd3:    begin ma = e2_q[0]; mb = dv1_q; end
      4'd4:    begin ma = e2_q[0]; mb = du1_q; end
      4'd5:    begin ma = e1_q[0]; mb = du2_q; end
      4'd6:    begin ma = e1_q[1]; mb = dv2_q; end
      4'd7:    begin ma = e2_q[1]; mb = dv1_q; end
      4'd8:    begin ma = e2_q[1]; mb = du1_q; end
      4'd9:    begin ma = e1_q[1]; mb = du2_q; end
      4'd10:   begin ma = e1_q[2]; mb = dv2_q; end
      4'd11:   begin ma = e2_q[2]; mb = dv1_q; end
      4'd12:   begin ma = e2_q[2]; mb = du1_q; end
      4'd13:   begin ma = e1_q[2]; mb = du2_q; end
      default: begin ma = '0;      mb = '0;    end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pval_q <= 1'b0;
    end else begin
      pval_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q  <= ma * mb;
      pstep_q <= cmd_i.mul_step;
    end
    if (pval_q) begin
      if (!pstep_q[0]) hold_q <= prod_q;
      else res_q[pstep_q[3:1]] <= WIDE_W'(hold_q) - WIDE_W'(prod_q);
    end
  end

  mta_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (res_q[3'(cmd_i.div_sel + 3'd1)]),
    .den_i   (res_q[0]),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .clamp_o (div_clamp)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) dsel_q <= cmd_i.div_sel;
    if (cmd_i.diff_en) begin
      clamp_q <= 1'b0;
    end else if (div_done) begin
      clamp_q <= clamp_q | div_clamp;
    end
    if (div_done) quo_q[dsel_q] <= div_quo;
  end

  // quotient order: tan x, bit x, tan y, bit y, tan z, bit z
  assign r0 = sat_add(srd_q.tx, quo_q[0]);
  assign r1 = sat_add(srd_q.ty, quo_q[2]);
  assign r2 = sat_add(srd_q.tz, quo_q[4]);
  assign r3 = sat_add(srd_q.bx, quo_q[1]);
  assign r4 = sat_add(srd_q.by, quo_q[3]);
  assign r5 = sat_add(srd_q.bz, quo_q[5]);
  assign sats = {r5[32], r4[32], r3[32], r2[32], r1[32], r0[32]};

  always_comb begin
    new_sum.tx   = r0[31:0];
    new_sum.ty   = r1[31:0];
    new_sum.tz   = r2[31:0];
    new_sum.bx   = r3[31:0];
    new_sum.by   = r4[31:0];
    new_sum.bz   = r5[31:0];
    new_sum.mark = srd_q.mark | clamp_q | (|sats);
  end

  // sum store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && in_range) begin
      smem[addr_first] <= '0;
    end else if (cmd_i.sum_wr) begin
      smem[addr] <= new_sum;
    end
    if (cmd_i.sum_rd) srd_q <= smem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (in_range) begin
        out_q <= '{srd_q.tx, srd_q.ty, srd_q.tz, srd_q.bx, srd_q.by, srd_q.bz,
                   srd_q.mark};
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.in_range = in_range;
  assign sts_o.det_zero = (res_q[0] == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> hdl/mta_ctrl.sv
// ----------------------------------------------------------------------------
// mta_ctrl
// Sequencer: steps a load, read or triangle (fetch, multiply, divide, accumulate).
// ----------------------------------------------------------------------------
`default_nettype none

module mta_ctrl import mta_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire mode_e in_mode_i,
  output logic       in_ready_o,
  input  wire sts_t  sts_i,
  output cmd_t       cmd_o
);

  state_e     st_q, st_d;
  logic [3:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_mode_i)
            MODE_LOAD: st_d = S_LOAD;
            MODE_TRI:  st_d = S_FETCH;
            MODE_READ: st_d = S_RRD;
            default:   st_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        st_d          = S_IDLE;
      end
      S_FETCH: begin
        if (cnt_q == 4'd0 && !sts_i.in_range) begin
          st_d = S_IDLE;
        end else begin
          cmd_o.vtx_rd     = (cnt_q < 4'd3);
          cmd_o.corner     = cnt_q[1:0];
          cmd_o.vtx_cap    = (cnt_q != 4'd0);
          cmd_o.cap_corner = 2'(cnt_q - 4'd1);
          cnt_d            = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            cnt_d = '0;
            st_d  = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        st_d          = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en   = (cnt_q < 4'(MUL_STEPS));
        cmd_o.mul_step = cnt_q;
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'(MUL_STEPS)) begin
          cnt_d = '0;
          st_d  = S_CHK;
        end
      end
      S_CHK: begin
        st_d = sts_i.det_zero ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = cnt_q[2:0];
        st_d            = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          if (cnt_q == 4'(N_QUOT - 1)) begin
            cnt_d = '0;
            st_d  = S_ARD;
          end else begin
            cnt_d = cnt_q + 4'd1;
            st_d  = S_DIV;
          end
        end
      end
      S_ARD: begin
        cmd_o.sum_rd = 1'b1;
        cmd_o.corner = cnt_q[1:0];
        st_d         = S_AWR;
      end
      S_AWR: begin
        cmd_o.sum_wr = 1'b1;
        cmd_o.corner = cnt_q[1:0];
        if (cnt_q == 4'd2) begin
          cnt_d = '0;
          st_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q + 4'd1;
          st_d  = S_ARD;
        end
      end
      S_RRD: begin
        cmd_o.sum_rd = 1'b1;
        st_d         = S_ROUT;
      end
      S_ROUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          st_d           = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/mesh_tangent_accumulator_core.sv
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator_core
// Per-triangle tangent and bitangent accumulation into vertex slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : items of three kinds. Load writes a vertex slot and clears its
//           sums; triangle adds the triangle's tangent and bitangent into its
//           three corners; read returns one result item on out_o.
//   out_o : one item per read, held in an output register until taken.
// Sequence (one item at a time, in_i ready only while idle):
//   load      accept, then write the vertex slot and clear its sums
//   read      accept, sum memory read, then the result register, which waits
//             while out_o stalls
//   triangle  accept, fetch of the three corners, differences, the products on
//             the shared 33x33 multiplier, determinant check, six quotients on
//             the one-bit-per-cycle divider (cut short on an early overflow),
//             then three read-modify-writes on the sum memory port. A zero determinant ends after the check.
// Reset clears the sequencer and the output valid; slot contents are not
// cleared and a slot must be loaded before it is used or read.
// A stalled result holds out_o; a following read waits for it to be taken,
// other items go on meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_tangent_accumulator_core import mta_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mta_in_if.sink     in_i,
  mta_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  mta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.data.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mta_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

`default_nettype wire

>>> hdl/mta_checker.sv
// ----------------------------------------------------------------------------
// mta_checker
// Port-level checks for the mesh tangent accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_checker import mta_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire mode_e     in_mode_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result item changed while stalled");

  // an unused mode is dropped in the idle state, so ready may stay high
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i != MODE_NONE) |=> !in_ready_i)
    else $error("input taken while an item is in progress");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in progress");

endmodule

bind mesh_tangent_accumulator_core mta_checker u_mta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.data.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

>>> sim/mesh_tangent_accumulator_core_test.sv
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator_core_test
// Self-checking bench for the tangent accumulator. Loads vertices, sends
// triangles and reads back slot sums under random stalls on both channels.
// Every read result is checked against an in-bench fixed-point predictor of
// the slot sums and the saturation marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mesh_tangent_accumulator_core_test;
  import mta_pkg::*;

  localparam int unsigned N_SLOTS     = 1024;
  localparam int unsigned N_RANDOM    = 1250;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mta_in_if  in_bus ();
  mta_out_if out_bus ();

  mesh_tangent_accumulator_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  int signed   slot_px [N_SLOTS];
  int signed   slot_py [N_SLOTS];
  int signed   slot_pz [N_SLOTS];
  int signed   slot_u  [N_SLOTS];
  int signed   slot_v  [N_SLOTS];
  int signed   sum_tan [N_SLOTS][3];
  int signed   sum_btn [N_SLOTS][3];
  bit          sat_mark[N_SLOTS];

  in_item_t    pending_items[$];
  out_item_t   expected_sums[$];
  bit          written[N_SLOTS];
  int unsigned written_list[$];

  int unsigned items_accepted = 0;
  int unsigned sums_checked = 0;
  int unsigned sat_reads = 0;
  int unsigned n_load = 0, n_tri = 0, n_read = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic int unsigned send_idle_pct();
    if (items_accepted < 420) return 34;
    if (items_accepted < 840) return 47;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (items_accepted < 420) return 47;
    if (items_accepted < 840) return 34;
    return 0;
  endfunction

  function automatic int signed sat_add(int signed s, int signed a, ref bit sat);
    longint t;
    t = longint'(s) + longint'(a);
    if (t > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (t < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return int'(t);
  endfunction

  function automatic int signed q16_quot(logic signed [127:0] num,
                                         logic signed [127:0] det, ref bit clamped);
    logic signed [127:0] q;
    q = (num <<< 16) / det;
    if (q > Q_MAX) begin
      clamped = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (q < Q_MIN) begin
      clamped = 1'b1;
      return 32'sh80000000;
    end
    return int'(q);
  endfunction

  task automatic accumulate_triangle(int unsigned i0, int unsigned i1, int unsigned i2);
    logic signed [127:0] e1[3], e2[3];
    logic signed [127:0] du1, dv1, du2, dv2, det;
    int signed tan[3], btn[3];
    int unsigned corner[3];
    bit clamped, sat;
    clamped = 1'b0;
    e1[0] = 128'(slot_px[i1]) - 128'(slot_px[i0]);
    e1[1] = 128'(slot_py[i1]) - 128'(slot_py[i0]);
    e1[2] = 128'(slot_pz[i1]) - 128'(slot_pz[i0]);
    e2[0] = 128'(slot_px[i2]) - 128'(slot_px[i0]);
    e2[1] = 128'(slot_py[i2]) - 128'(slot_py[i0]);
    e2[2] = 128'(slot_pz[i2]) - 128'(slot_pz[i0]);
    du1 = 128'(slot_u[i1]) - 128'(slot_u[i0]);
    dv1 = 128'(slot_v[i1]) - 128'(slot_v[i0]);
    du2 = 128'(slot_u[i2]) - 128'(slot_u[i0]);
    dv2 = 128'(slot_v[i2]) - 128'(slot_v[i0]);
    det = du1 * dv2 - dv1 * du2;
    if (det == 0) return;
    for (int c = 0; c < 3; c++) begin
      tan[c] = q16_quot(e1[c] * dv2 - e2[c] * dv1, det, clamped);
      btn[c] = q16_quot(e2[c] * du1 - e1[c] * du2, det, clamped);
    end
    corner[0] = i0;
    corner[1] = i1;
    corner[2] = i2;
    for (int k = 0; k < 3; k++) begin
      sat = clamped;
      for (int c = 0; c < 3; c++) begin
        sum_tan[corner[k]][c] = sat_add(sum_tan[corner[k]][c], tan[c], sat);
        sum_btn[corner[k]][c] = sat_add(sum_btn[corner[k]][c], btn[c], sat);
      end
      if (sat) sat_mark[corner[k]] = 1'b1;
    end
  endtask

  task automatic predict_item(in_item_t it);
    out_item_t r;
    int unsigned a;
    a = 32'(it.first_index);
    case (it.mode)
      MODE_LOAD: begin
        n_load++;
        slot_px[a] = it.pos_x;
        slot_py[a] = it.pos_y;
        slot_pz[a] = it.pos_z;
        slot_u[a]  = it.tex_u;
        slot_v[a]  = it.tex_v;
        for (int c = 0; c < 3; c++) begin
          sum_tan[a][c] = 0;
          sum_btn[a][c] = 0;
        end
        sat_mark[a] = 1'b0;
      end
      MODE_TRI: begin
        n_tri++;
        accumulate_triangle(a, 32'(it.second_index), 32'(it.third_index));
      end
      MODE_READ: begin
        n_read++;
        r.tangent_x   = sum_tan[a][0];
        r.tangent_y   = sum_tan[a][1];
        r.tangent_z   = sum_tan[a][2];
        r.bitangent_x = sum_btn[a][0];
        r.bitangent_y = sum_btn[a][1];
        r.bitangent_z = sum_btn[a][2];
        r.saturated   = sat_mark[a];
        expected_sums = {expected_sums, r};
      end
      default: ;
    endcase
  endtask

  // stimulus helpers
  task automatic queue_load(int unsigned idx, int signed px, int signed py, int signed pz,
                            int signed u, int signed v);
    in_item_t it;
    it.mode         = MODE_LOAD;
    it.first_index  = 10'(idx);
    it.second_index = 10'($urandom_range(0, 1023));
    it.third_index  = 10'($urandom_range(0, 1023));
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.tex_u = u;
    it.tex_v = v;
    pending_items = {pending_items, it};
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list = {written_list, idx};
    end
  endtask

  task automatic queue_op(mode_e m, int unsigned a, int unsigned b, int unsigned c);
    in_item_t it;
    it.mode         = m;
    it.first_index  = 10'(a);
    it.second_index = 10'(b);
    it.third_index  = 10'(c);
    it.pos_x = $urandom();
    it.pos_y = $urandom();
    it.pos_z = $urandom();
    it.tex_u = $urandom();
    it.tex_v = $urandom();
    pending_items = {pending_items, it};
  endtask

  function automatic int signed rand_q16();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3:    return $urandom();
      default: return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endcase
  endfunction

  function automatic int unsigned pick_written();
    if (written_list.size() > 12 && $urandom_range(0, 3) == 0)
      return written_list[$urandom_range(0, written_list.size() - 1)];
    return written_list[$urandom_range(0, 11)];
  endfunction

  // driver
  always @(posedge clk_i) begin
    in_item_t nxt;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_item(pending_items.pop_front());
        items_accepted++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the current item
      end else if (pending_items.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct()) begin
        nxt = pending_items[0];
        in_bus.valid <= 1'b1;
        in_bus.data  <= nxt;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t want, got;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.data;
        if (expected_sums.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = expected_sums.pop_front();
          sums_checked++;
          if (got.saturated) sat_reads++;
          if (got.tangent_x !== want.tangent_x)
            $display("%0t: tangent_x exp %h got %h", $time, want.tangent_x, got.tangent_x);
          if (got.tangent_y !== want.tangent_y)
            $display("%0t: tangent_y exp %h got %h", $time, want.tangent_y, got.tangent_y);
          if (got.tangent_z !== want.tangent_z)
            $display("%0t: tangent_z exp %h got %h", $time, want.tangent_z, got.tangent_z);
          if (got.bitangent_x !== want.bitangent_x)
            $display("%0t: bitangent_x exp %h got %h", $time, want.bitangent_x,
                     got.bitangent_x);
          if (got.bitangent_y !== want.bitangent_y)
            $display("%0t: bitangent_y exp %h got %h", $time, want.bitangent_y,
                     got.bitangent_y);
          if (got.bitangent_z !== want.bitangent_z)
            $display("%0t: bitangent_z exp %h got %h", $time, want.bitangent_z,
                     got.bitangent_z);
          if (got.saturated !== want.saturated)
            $display("%0t: saturated exp %b got %b", $time, want.saturated, got.saturated);
          if (got !== want) errors++;
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && sums_checked == 40) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress", $time);
      $display("mesh_tangent_accumulator_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;

    // directed: ordinary triangle, extremes, degenerate UVs, repeated corner
    queue_load(0, 0, 0, 0, 0, 0);
    queue_load(1, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 0);
    queue_load(2, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000);
    queue_op(MODE_TRI, 0, 1, 2);
    queue_op(MODE_READ, 0, 0, 0);
    queue_load(3, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh0000_0001, 0);
    queue_load(1023, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 32'sh0000_0001);
    queue_op(MODE_TRI, 0, 3, 1023);
    queue_op(MODE_TRI, 0, 3, 1023);
    queue_op(MODE_READ, 3, 0, 0);
    queue_op(MODE_READ, 1023, 1023, 1023);
    queue_load(4, 32'sh0005_0000, 32'sh0003_0000, 32'sh0002_0000, 0, 0);
    queue_op(MODE_TRI, 0, 4, 0);
    queue_op(MODE_TRI, 1, 1, 2);
    queue_op(MODE_READ, 4, 0, 0);
    queue_op(MODE_NONE, 1023, 1023, 1023);
    queue_op(MODE_READ, 1, 0, 0);
    queue_op(MODE_READ, 2, 0, 0);
    for (int unsigned i = 5; i < 12; i++)
      queue_load(i, rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());

    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        queue_load(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 11),
                   rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
      end else if (r < 70) begin
        queue_op(MODE_TRI, pick_written(), pick_written(), pick_written());
      end else if (r < 96) begin
        queue_op(MODE_READ, pick_written(), $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        queue_op(MODE_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_bus.valid || expected_sums.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("%0d loads, %0d triangles, %0d reads accepted; %0d results checked",
             n_load, n_tri, n_read, sums_checked);
    $display("%0d results carried the saturation mark", sat_reads);
    if (errors == 0 && expected_sums.size() == 0)
      $display("mesh_tangent_accumulator_core_test OK");
    else
      $display("mesh_tangent_accumulator_core_test NOT OK");
    $finish;
  end

endmodule
